### hw/rtl/packet_deframer_crc_check_assert.svh
// Assertion macros for the packet deframer
`ifndef PACKET_DEFRAMER_CRC_CHECK_ASSERT_SVH
`define PACKET_DEFRAMER_CRC_CHECK_ASSERT_SVH
// implication checked on every clock, off during reset
`define PDC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PDC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/pdc_pkg.sv
// Shared types, constants and CRC functions of the packet deframer
`timescale 1ns / 1ps
package pdc_pkg;
  localparam logic [7:0] MagicA = 8'hA5;
  localparam logic [7:0] MagicB = 8'hC3;
  localparam logic [13:0] MaxPayload = 14'd16383;

  localparam logic [1:0] EvTrash = 2'd0;
  localparam logic [1:0] EvPayload = 2'd1;
  localparam logic [1:0] EvGood = 2'd2;
  localparam logic [1:0] EvBad = 2'd3;

  localparam logic [1:0] CkNone = 2'd0;
  localparam logic [1:0] Ck8 = 2'd1;
  localparam logic [1:0] Ck16 = 2'd2;
  localparam logic [1:0] Ck32 = 2'd3;

  localparam logic [2:0] HdrBytes = 3'd7;

  // controller commands to datapath
  typedef struct packed {
    logic       load;      // shift in rx byte to window
    logic       drop;      // emit and drop window[0]
    logic       hdr_err;   // count header error with drop
    logic       accept;    // take header
    logic       pay;       // payload byte
    logic       trl;       // trailer byte
    logic       fin;       // emit end event
    logic       fin_good;
    logic       last;
    logic       emit_pay;
  } pdc_cmd_t;

  // datapath status to controller
  typedef struct packed {
    logic [2:0]  fill;
    logic        magic0;    // window[0..1] is magic pair
    logic        magic1;    // window[1..2] is magic pair
    logic        any_magic; // a magic pair exists in held bytes
    logic        hdr_ok;
    logic        len_zero;
    logic [13:0] remaining;
    logic [1:0]  kind;
    logic        trl_ok;
  } pdc_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] poly_for(input logic [1:0] k);
    case (k)
      Ck8: return 32'h0000_008C;
      Ck16: return 32'h0000_A001;
      default: return 32'hEDB8_8320;
    endcase
  endfunction

  function automatic logic [2:0] trl_size(input logic [1:0] k);
    case (k)
      Ck8: return 3'd1;
      Ck16: return 3'd2;
      Ck32: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction
endpackage

### hw/rtl/pdc_datapath.sv
// Datapath: header window, CRC, trailer, counters and output register
`timescale 1ns / 1ps
module pdc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  pdc_pkg::pdc_cmd_t cmd_i,
  output pdc_pkg::pdc_sts_t sts_o,
  output logic [1:0]       event_kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       command_o,
  output logic [7:0]       sequence_res_o,
  output logic [13:0]      payload_length_o,
  output logic             last_o,
  output logic [31:0]      trash_total_o,
  output logic [31:0]      header_error_total_o,
  output logic [31:0]      crc_error_total_o,
  output logic [31:0]      packet_total_o
);
  import pdc_pkg::*;

  logic [7:0] win_q [7];
  logic [2:0] fill_q;
  logic [13:0] rem_q;
  logic [1:0] kind_q;
  logic [31:0] crc_q, trl_q;
  logic [29:0] info_q;
  logic [31:0] trash_q, herr_q, cerr_q, pkt_q;
  logic [7:0] hcrc;
  logic [13:0] hlen;
  logic [31:0] want, mask, trl_full;
  logic [1:0] tidx;
  logic found;

  always_comb begin
    hcrc = '0;
    for (int i = 2; i < 6; i++) begin
      hcrc = 8'(crc_byte({24'd0, hcrc}, win_q[i], 32'h8C));
    end
    hlen = {win_q[3][5:0], win_q[2]};
    found = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if ((3'(i + 1) < fill_q) && win_q[i] == MagicA && win_q[i + 1] == MagicB) begin
        found = 1'b1;
      end
    end
    tidx = 2'(trl_size(kind_q) - 3'(rem_q));
    trl_full = trl_q | ({24'd0, rx_byte_i} << {tidx, 3'd0});
    want = (kind_q == Ck32) ? ~crc_q : crc_q;
    mask = (kind_q == Ck8) ? 32'hFF : (kind_q == Ck16) ? 32'hFFFF : 32'hFFFF_FFFF;
    sts_o.fill = fill_q;
    sts_o.magic0 = (fill_q >= 3'd2) && win_q[0] == MagicA && win_q[1] == MagicB;
    sts_o.magic1 = (fill_q >= 3'd3) && win_q[1] == MagicA && win_q[2] == MagicB;
    sts_o.any_magic = found;
    sts_o.hdr_ok = (hcrc == win_q[6]) && (hlen <= MaxPayload);
    sts_o.len_zero = (hlen == 14'd0);
    sts_o.remaining = rem_q;
    sts_o.kind = kind_q;
    sts_o.trl_ok = (want & mask) == (trl_full & mask);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[(fill_q == HdrBytes) ? 3'd6 : fill_q] <= rx_byte_i;
    end else if (cmd_i.drop) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q <= '0;
      kind_q <= '0;
      crc_q <= '0;
      trl_q <= '0;
      info_q <= '0;
      trash_q <= '0;
      herr_q <= '0;
      cerr_q <= '0;
      pkt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        fill_q <= (fill_q == HdrBytes) ? HdrBytes : fill_q + 3'd1;
      end else if (cmd_i.drop) begin
        fill_q <= fill_q - 3'd1;
        trash_q <= trash_q + 32'd1;
        if (cmd_i.hdr_err) begin
          herr_q <= herr_q + 32'd1;
        end
      end else if (cmd_i.accept) begin
        fill_q <= '0;
        info_q <= {win_q[5], win_q[4], hlen};
        kind_q <= win_q[3][7:6];
        rem_q <= hlen;
        crc_q <= (win_q[3][7:6] == Ck16) ? 32'hFFFF :
                 (win_q[3][7:6] == Ck32) ? 32'hFFFF_FFFF : 32'd0;
        trl_q <= '0;
      end else if (cmd_i.pay) begin
        if (kind_q != CkNone) begin
          crc_q <= crc_byte(crc_q, rx_byte_i, poly_for(kind_q));
        end
        if (rem_q == 14'd1) begin
          rem_q <= 14'(trl_size(kind_q));
          trl_q <= '0;
        end else begin
          rem_q <= rem_q - 14'd1;
        end
      end else if (cmd_i.trl) begin
        trl_q <= trl_full;
        rem_q <= rem_q - 14'd1;
      end
      if (cmd_i.fin) begin
        if (cmd_i.fin_good) begin
          pkt_q <= pkt_q + 32'd1;
        end else begin
          cerr_q <= cerr_q + 32'd1;
        end
      end
    end
  end

  // output register, loaded on each emitted result
  logic emit;
  assign emit = cmd_i.drop || cmd_i.fin || cmd_i.emit_pay;
  always_ff @(posedge clk_i) begin
    if (emit) begin
      last_o <= cmd_i.last;
      if (cmd_i.drop) begin
        event_kind_o <= EvTrash;
        data_byte_o <= win_q[0];
        trash_total_o <= trash_q + 32'd1;
        header_error_total_o <= cmd_i.hdr_err ? herr_q + 32'd1 : herr_q;
        crc_error_total_o <= cerr_q;
        packet_total_o <= pkt_q;
        command_o <= info_q[21:14];
        sequence_res_o <= info_q[29:22];
        payload_length_o <= info_q[13:0];
      end else if (cmd_i.emit_pay) begin
        event_kind_o <= EvPayload;
        data_byte_o <= rx_byte_i;
        trash_total_o <= trash_q;
        header_error_total_o <= herr_q;
        crc_error_total_o <= cerr_q;
        packet_total_o <= pkt_q;
        command_o <= info_q[21:14];
        sequence_res_o <= info_q[29:22];
        payload_length_o <= info_q[13:0];
      end else begin
        event_kind_o <= cmd_i.fin_good ? EvGood : EvBad;
        data_byte_o <= '0;
        trash_total_o <= trash_q;
        header_error_total_o <= herr_q;
        crc_error_total_o <= cmd_i.fin_good ? cerr_q : cerr_q + 32'd1;
        packet_total_o <= cmd_i.fin_good ? pkt_q + 32'd1 : pkt_q;
        command_o <= cmd_i.accept ? win_q[4] : info_q[21:14];
        sequence_res_o <= cmd_i.accept ? win_q[5] : info_q[29:22];
        payload_length_o <= cmd_i.accept ? hlen : info_q[13:0];
      end
    end
  end
endmodule

### hw/rtl/pdc_ctrl.sv
// Controller: phase state machine, hunt sequencing and output handshake
`timescale 1ns / 1ps
module pdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pdc_pkg::pdc_sts_t sts_i,
  output pdc_pkg::pdc_cmd_t cmd_o
);
  import pdc_pkg::*;
  `include "packet_deframer_crc_check_assert.svh"

  localparam logic [1:0] StHunt = 2'd0;
  localparam logic [1:0] StPay = 2'd1;
  localparam logic [1:0] StTrl = 2'd2;
  localparam logic [1:0] StScan = 2'd3;

  logic [1:0] state_q, state_d;
  logic ov_q, ov_d;
  logic pend_q, pend_d;   // pending end event after last payload byte
  logic free, acc;

  assign free = !ov_q || !out_stall;
  assign in_stall = !free || pend_q || state_q == StScan;
  assign acc = in_valid && !in_stall;
  assign out_valid = ov_q;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    ov_d = ov_q && out_stall;
    pend_d = pend_q;
    if (free && pend_q) begin
      cmd_o.fin = 1'b1;
      cmd_o.fin_good = 1'b1;
      cmd_o.last = 1'b1;
      ov_d = 1'b1;
      pend_d = 1'b0;
      state_d = StHunt;
    end else if (free && state_q == StScan) begin
      if (!sts_i.any_magic) begin
        if (sts_i.fill > 3'd1) begin
          cmd_o.drop = 1'b1;
          cmd_o.last = sts_i.fill == 3'd2;
          ov_d = 1'b1;
        end
        if (sts_i.fill <= 3'd2) state_d = StHunt;
      end else if (!sts_i.magic0) begin
        // the drop that brings the magic pair to the front closes the burst
        cmd_o.drop = 1'b1;
        cmd_o.last = sts_i.magic1;
        ov_d = 1'b1;
      end else if (sts_i.fill < HdrBytes) begin
        state_d = StHunt;
      end else if (!sts_i.hdr_ok) begin
        cmd_o.drop = 1'b1;
        cmd_o.hdr_err = 1'b1;
        ov_d = 1'b1;
      end else begin
        cmd_o.accept = 1'b1;
        if (sts_i.len_zero) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_good = 1'b1;
          cmd_o.last = 1'b1;
          ov_d = 1'b1;
          state_d = StHunt;
        end else begin
          state_d = StPay;
        end
      end
    end else if (acc) begin
      case (state_q)
        StPay: begin
          cmd_o.pay = 1'b1;
          cmd_o.emit_pay = 1'b1;
          ov_d = 1'b1;
          if (sts_i.remaining == 14'd1) begin
            if (sts_i.kind == CkNone) pend_d = 1'b1;
            else state_d = StTrl;
          end else begin
            cmd_o.last = 1'b1;
          end
          if (sts_i.remaining == 14'd1 && sts_i.kind != CkNone) cmd_o.last = 1'b1;
        end
        StTrl: begin
          cmd_o.trl = 1'b1;
          if (sts_i.remaining == 14'd1) begin
            cmd_o.fin = 1'b1;
            cmd_o.fin_good = sts_i.trl_ok;
            cmd_o.last = 1'b1;
            ov_d = 1'b1;
            state_d = StHunt;
          end
        end
        default: begin
          cmd_o.load = 1'b1;
          state_d = StScan;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
      ov_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      pend_q <= pend_d;
    end
  end

  `PDC_ASSERT_IMP(a_no_accept_scan, state_q == StScan, in_stall)
  `PDC_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd_o.load, cmd_o.drop, cmd_o.accept,
    cmd_o.pay, cmd_o.trl}))
  `PDC_ASSERT_NXT(a_pend_fin, pend_q && !out_stall, !pend_q)
endmodule

### hw/rtl/packet_deframer_crc_check.sv
// Top level of the packet deframer with header and payload CRC checks
// Usage:
//  Input channel rx_byte_i with in_valid / in_stall; output channel carries one
//  event per item (discarded byte, payload byte, good end, CRC error end) with
//  out_valid / out_stall, plus header fields, a last flag and four wrapping
//  counters. An input byte may cause zero to six results.
//  Payload and trailer bytes go straight through; a payload byte's item is
//  registered when it is accepted and shown in the next cycle. A hunt or header
//  byte is loaded into the window, then the input stalls while the scan state
//  steps: each step drops at most one byte, takes the header or returns to hunt.
//  A payload that ends without a trailer emits its good-end item in a pending
//  step, with the input stalled. The scan sequencer emits at most one result
//  per cycle through a single output register unless the receiver stalls.
//  While the receiver stalls a valid item, it holds and the input is stalled.
//  Reset clears state, counters and the output valid; the window needs none.
`timescale 1ns / 1ps
module packet_deframer_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  command_o,
  output logic [7:0]  sequence_res_o,
  output logic [13:0] payload_length_o,
  output logic        last_o,
  output logic [31:0] trash_total_o,
  output logic [31:0] header_error_total_o,
  output logic [31:0] crc_error_total_o,
  output logic [31:0] packet_total_o
);
  import pdc_pkg::*;

  pdc_cmd_t cmd;
  pdc_sts_t sts;

  pdc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  pdc_datapath u_dp (
    .clk_i, .rst_ni, .rx_byte_i, .cmd_i(cmd), .sts_o(sts),
    .event_kind_o, .data_byte_o, .command_o, .sequence_res_o, .payload_length_o,
    .last_o, .trash_total_o, .header_error_total_o, .crc_error_total_o,
    .packet_total_o
  );
endmodule

### tb/sv/tb_top.sv
// Testbench for the packet deframer: byte stream stimulus, predictor and scoreboard
`timescale 1ns / 1ps
module tb_top;
  import pdc_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  cmd;
    logic [7:0]  seqn;
    logic [13:0] len;
    logic        last;
    logic [31:0] trash;
    logic [31:0] hdr_err;
    logic [31:0] crc_err;
    logic [31:0] pkts;
  } event_t;

  class deframe_scoreboard;
    logic [7:0]  win[7];
    int          fill;
    int          mode;
    int          remaining;
    logic [1:0]  ck;
    logic [31:0] crc;
    logic [31:0] trl;
    logic [13:0] len;
    logic [7:0]  cmd;
    logic [7:0]  seqn;
    logic [31:0] trash, hdr_err, crc_err, pkts;
    event_t      pending[$];
    int          errors;
    int          n_events;

    function new();
      fill = 0; mode = 0; remaining = 0; ck = CkNone; crc = 0; trl = 0;
      len = 0; cmd = 0; seqn = 0; trash = 0; hdr_err = 0; crc_err = 0; pkts = 0;
      errors = 0; n_events = 0;
    endfunction

    function void push_event(logic [1:0] k, logic [7:0] d);
      event_t e;
      e = '{k, d, cmd, seqn, len, 1'b0, trash, hdr_err, crc_err, pkts};
      pending.push_back(e);
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b, logic [31:0] poly);
      c = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      return c;
    endfunction

    function void drop_first();
      trash++;
      push_event(EvTrash, win[0]);
      for (int i = 1; i < fill; i++) win[i-1] = win[i];
      if (fill > 0) fill--;
    endfunction

    function void end_packet(bit good);
      if (good) begin
        pkts++;
        push_event(EvGood, 8'd0);
      end else begin
        crc_err++;
        push_event(EvBad, 8'd0);
      end
      mode = 0;
      remaining = 0;
    endfunction

    function void scan();
      int pos;
      logic [7:0] hc;
      logic [13:0] l;
      forever begin
        pos = 7;
        for (int i = 0; i + 1 < fill; i++)
          if (win[i] == MagicA && win[i+1] == MagicB) begin
            pos = i;
            break;
          end
        if (pos == 7) begin
          while (fill > 1) drop_first();
          return;
        end
        if (pos > 0) begin
          drop_first();
          continue;
        end
        if (fill < 7) return;
        hc = 0;
        for (int i = 2; i < 6; i++) hc = 8'(crc_step({24'd0, hc}, win[i], 32'h8C));
        l = {win[3][5:0], win[2]};
        if (hc != win[6] || l > MaxPayload) begin
          hdr_err++;
          drop_first();
          continue;
        end
        len = l; cmd = win[4]; seqn = win[5]; ck = win[3][7:6]; fill = 0;
        if (l == 0) begin
          end_packet(1);
          return;
        end
        mode = 1;
        remaining = l;
        crc = (ck == Ck16) ? 32'hFFFF : (ck == Ck32) ? 32'hFFFF_FFFF : 32'd0;
        trl = 0;
        return;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int n_before;
      logic [31:0] want, mask;
      n_before = pending.size();
      if (mode == 1) begin
        push_event(EvPayload, b);
        if (ck != CkNone) crc = crc_step(crc, b, poly_for(ck));
        remaining--;
        if (remaining == 0) begin
          if (ck == CkNone) end_packet(1);
          else begin
            mode = 2;
            remaining = trl_size(ck);
            trl = 0;
          end
        end
      end else if (mode == 2) begin
        trl |= {24'd0, b} << (8 * ((trl_size(ck) - remaining) & 3));
        remaining--;
        if (remaining == 0) begin
          want = (ck == Ck32) ? ~crc : crc;
          mask = (ck == Ck8) ? 32'hFF : (ck == Ck16) ? 32'hFFFF : 32'hFFFF_FFFF;
          end_packet((want & mask) == (trl & mask));
        end
      end else begin
        if (fill >= 7) fill = 6;
        win[fill] = b;
        fill++;
        scan();
      end
      if (pending.size() > n_before) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_event(event_t got);
      event_t exp;
      n_events++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  rx_byte_i = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  event_kind_o;
  logic [7:0]  data_byte_o, command_o, sequence_res_o;
  logic [13:0] payload_length_o;
  logic        last_o;
  logic [31:0] trash_total_o, header_error_total_o, crc_error_total_o, packet_total_o;

  deframe_scoreboard sb = new();
  logic [7:0] stream[$];
  bit         stim_done = 0;
  int         cycles = 0;

  always #1 clk_i = ~clk_i;

  packet_deframer_crc_check i_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall)
      sb.check_event('{event_kind_o, data_byte_o, command_o, sequence_res_o,
                       payload_length_o, last_o, trash_total_o, header_error_total_o,
                       crc_error_total_o, packet_total_o});

  function automatic logic [31:0] payload_crc(logic [1:0] k, logic [7:0] p[$]);
    logic [31:0] c;
    c = (k == Ck16) ? 32'hFFFF : (k == Ck32) ? 32'hFFFF_FFFF : 32'd0;
    foreach (p[i]) c = sb.crc_step(c, p[i], poly_for(k));
    return (k == Ck32) ? ~c : c;
  endfunction

  // queue one framed packet; bad_hdr and bad_trl select header or trailer damage
  task automatic add_packet(int n, logic [1:0] k, bit bad_hdr, bit bad_trl);
    logic [7:0] h[7];
    logic [7:0] p[$];
    logic [7:0] hc;
    logic [31:0] c;
    h[0] = MagicA; h[1] = MagicB;
    h[2] = n[7:0]; h[3] = {k, n[13:8]};
    h[4] = 8'($urandom); h[5] = 8'($urandom);
    hc = 0;
    for (int i = 2; i < 6; i++) hc = 8'(sb.crc_step({24'd0, hc}, h[i], 32'h8C));
    h[6] = bad_hdr ? ~hc : hc;
    for (int i = 0; i < 7; i++) stream.push_back(h[i]);
    for (int i = 0; i < n; i++) p.push_back(8'($urandom));
    foreach (p[i]) stream.push_back(p[i]);
    if (n > 0 && !bad_hdr) begin
      c = payload_crc(k, p);
      if (bad_trl) c ^= 32'h1 << $urandom_range(0, 8 * trl_size(k) - 1);
      for (int i = 0; i < trl_size(k); i++) stream.push_back(c[8*i +: 8]);
    end
  endtask

  initial begin
    int gap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    stream.push_back(8'h00); stream.push_back(8'hFF); stream.push_back(MagicA);
    add_packet(0, CkNone, 0, 0);
    add_packet(2, Ck8, 0, 0);
    add_packet(1, Ck16, 0, 1);
    add_packet(1, Ck32, 1, 0);
    add_packet(3, Ck32, 0, 0);
    add_packet(1, CkNone, 0, 0);
    // random
    while (stream.size() < 220) begin
      case ($urandom_range(0, 9))
        0: stream.push_back(8'($urandom));
        1: stream.push_back(MagicA);
        default: add_packet($urandom_range(0, 9), 2'($urandom), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 5) == 0);
      endcase
    end
    // a couple of longer payloads
    add_packet(12, Ck16, 0, 0);
    add_packet(10, Ck32, 0, 1);
    while (stream.size() > 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1;
      rx_byte_i <= stream[0];
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      sb.note_byte(stream.pop_front());
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    int stall_len;
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    out_stall <= 1;
    repeat (300) @(posedge clk_i);
    forever begin
      stall_len = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (stall_len > 0) begin
        out_stall <= 1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall <= 0;
      @(posedge clk_i);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
